// ===== hdl/rpcw_pkg.sv =====
// Shared types, codes and command length tables for the RTS PDU command walker.
package rpcw_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       pdu_start;
    } in_item_t;

    typedef enum logic [2:0] {
        EV_CMD_DONE    = 3'd0,
        EV_EMPTY_PDU   = 3'd1,
        EV_PING        = 3'd2,
        EV_BAD_PTYPE   = 3'd3,
        EV_UNKNOWN_CMD = 3'd4
    } event_kind_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [31:0] command_type;
        logic [32:0] body_length;
        logic [15:0] command_number;
        logic        last_command;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_TYPE   = 3'd2,
        PH_PARAM  = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    localparam logic [7:0]  RTS_PTYPE        = 8'h14;
    localparam logic [4:0]  POS_PTYPE        = 5'd2;
    localparam logic [4:0]  POS_FLAGS_LO     = 5'd16;
    localparam logic [4:0]  POS_COUNT_LO     = 5'd18;
    localparam logic [4:0]  POS_COUNT_HI     = 5'd19;
    localparam logic [31:0] NUM_TYPES        = 32'd15;
    localparam logic [3:0]  TYPE_PADDING     = 4'd8;
    localparam logic [3:0]  TYPE_CLIENT_ADDR = 4'd11;

    // Fixed body length of each known command type.
    function automatic logic [4:0] fixed_len(input logic [3:0] cmd_type);
        logic [4:0] len;
        unique case (cmd_type)
            4'd1:        len = 5'd24;
            4'd3, 4'd12: len = 5'd16;
            4'd0, 4'd2, 4'd4, 4'd5, 4'd6, 4'd13, 4'd14: len = 5'd4;
            default:     len = 5'd0;
        endcase
        return len;
    endfunction

    // Body bytes left to skip once the parameter word of a variable command is read.
    function automatic logic [31:0] param_skip(input logic [3:0] cmd_type,
                                               input logic [31:0] word);
        logic [31:0] skip;
        if (cmd_type == TYPE_PADDING) begin
            skip = word;
        end else begin
            skip = (word == 32'd0) ? 32'd16 : 32'd28;
        end
        return skip;
    endfunction

    // Full body length of a command, type word excluded.
    function automatic logic [32:0] body_of(input logic [3:0] cmd_type,
                                            input logic [31:0] word);
        logic [32:0] len;
        if (cmd_type == TYPE_PADDING) begin
            len = {1'b0, word} + 33'd4;
        end else if (cmd_type == TYPE_CLIENT_ADDR) begin
            len = (word == 32'd0) ? 33'd20 : 33'd32;
        end else begin
            len = {28'd0, fixed_len(cmd_type)};
        end
        return len;
    endfunction

endpackage

// ===== hdl/rpcw_in_stage.sv =====
// Input register stage that holds one received item for the walker.
module rpcw_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpcw_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              in_valid,
    output rpcw_pkg::in_item_t in_item
);

    logic               valid_reg;
    rpcw_pkg::in_item_t item_reg;

    assign s_ready  = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hdl/rpcw_walker.sv =====
// Header parser and command walker state machine, one byte per advance.
module rpcw_walker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  rpcw_pkg::in_item_t in_item,
    output logic               res_valid,
    output rpcw_pkg::out_item_t res_item
);

    rpcw_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [4:0]  pos_reg, pos_next, pos_cur;
    logic [1:0]  cnt_reg, cnt_next, cnt_cur;
    logic [15:0] counter_reg, counter_next, counter_cur;
    logic [15:0] left_reg, left_next;
    logic        ping_reg, ping_next;
    logic [31:0] gather_reg, gather_next;
    logic [3:0]  type_reg, type_next;
    logic [31:0] skip_reg, skip_next;

    logic [7:0]  b;
    logic [31:0] gathered;
    logic        word_done;
    logic        do_finish;
    logic [3:0]  fin_type;
    logic [32:0] fin_body;
    logic [31:0] pskip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= rpcw_pkg::PH_IDLE;
            pos_reg     <= 5'd0;
            cnt_reg     <= 2'd0;
            counter_reg <= 16'd0;
            left_reg    <= 16'd0;
            ping_reg    <= 1'b0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            counter_reg <= counter_next;
            left_reg    <= left_next;
            ping_reg    <= ping_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gather_reg <= gather_next;
            type_reg   <= type_next;
            skip_reg   <= skip_next;
        end
    end

    always_comb begin
        b           = in_item.data_byte;
        // a start marker restarts the walk at header byte 0
        phase_cur   = in_item.pdu_start ? rpcw_pkg::PH_HEADER : phase_reg;
        pos_cur     = in_item.pdu_start ? 5'd0 : pos_reg;
        cnt_cur     = in_item.pdu_start ? 2'd0 : cnt_reg;
        counter_cur = in_item.pdu_start ? 16'd0 : counter_reg;

        gathered  = ((cnt_cur == 2'd0) ? 32'd0 : gather_reg)
                    | ({24'd0, b} << {cnt_cur, 3'b000});
        word_done = (cnt_cur == 2'd3);
        pskip     = rpcw_pkg::param_skip(type_reg, gathered);

        phase_next   = phase_cur;
        pos_next     = pos_cur;
        cnt_next     = cnt_cur;
        counter_next = counter_cur;
        left_next    = left_reg;
        ping_next    = ping_reg;
        gather_next  = gather_reg;
        type_next    = type_reg;
        skip_next    = skip_reg;

        do_finish = 1'b0;
        fin_type  = type_reg;
        fin_body  = 33'd0;
        res_valid = 1'b0;
        res_item  = '0;

        unique case (phase_cur)
            rpcw_pkg::PH_HEADER: begin
                pos_next = pos_cur + 5'd1;
                if (pos_cur == rpcw_pkg::POS_PTYPE && b != rpcw_pkg::RTS_PTYPE) begin
                    phase_next            = rpcw_pkg::PH_DONE;
                    res_valid             = 1'b1;
                    res_item.event_kind   = rpcw_pkg::EV_BAD_PTYPE;
                    res_item.command_type = {24'd0, b};
                end else if (pos_cur == rpcw_pkg::POS_FLAGS_LO) begin
                    ping_next = b[0];
                end else if (pos_cur == rpcw_pkg::POS_COUNT_LO) begin
                    left_next = {8'd0, b};
                end else if (pos_cur == rpcw_pkg::POS_COUNT_HI) begin
                    left_next = {b, left_reg[7:0]};
                    cnt_next  = 2'd0;
                    if (ping_reg) begin
                        phase_next          = rpcw_pkg::PH_DONE;
                        res_valid           = 1'b1;
                        res_item.event_kind = rpcw_pkg::EV_PING;
                    end else if ({b, left_reg[7:0]} == 16'd0) begin
                        phase_next          = rpcw_pkg::PH_DONE;
                        res_valid           = 1'b1;
                        res_item.event_kind = rpcw_pkg::EV_EMPTY_PDU;
                    end else begin
                        phase_next = rpcw_pkg::PH_TYPE;
                    end
                end
            end
            rpcw_pkg::PH_TYPE: begin
                gather_next = gathered;
                cnt_next    = cnt_cur + 2'd1;
                if (word_done) begin
                    type_next = gathered[3:0];
                    if (gathered >= rpcw_pkg::NUM_TYPES) begin
                        phase_next              = rpcw_pkg::PH_DONE;
                        res_valid               = 1'b1;
                        res_item.event_kind     = rpcw_pkg::EV_UNKNOWN_CMD;
                        res_item.command_type   = gathered;
                        res_item.command_number = counter_cur;
                        res_item.last_command   = (left_reg == 16'd1);
                    end else if (gathered[3:0] == rpcw_pkg::TYPE_PADDING ||
                                 gathered[3:0] == rpcw_pkg::TYPE_CLIENT_ADDR) begin
                        phase_next = rpcw_pkg::PH_PARAM;
                    end else if (rpcw_pkg::fixed_len(gathered[3:0]) == 5'd0) begin
                        do_finish = 1'b1;
                        fin_type  = gathered[3:0];
                    end else begin
                        skip_next  = {27'd0, rpcw_pkg::fixed_len(gathered[3:0])};
                        phase_next = rpcw_pkg::PH_SKIP;
                    end
                end
            end
            rpcw_pkg::PH_PARAM: begin
                gather_next = gathered;
                cnt_next    = cnt_cur + 2'd1;
                if (word_done) begin
                    if (pskip == 32'd0) begin
                        do_finish = 1'b1;
                        fin_body  = rpcw_pkg::body_of(type_reg, gathered);
                    end else begin
                        skip_next  = pskip;
                        phase_next = rpcw_pkg::PH_SKIP;
                    end
                end
            end
            rpcw_pkg::PH_SKIP: begin
                skip_next = skip_reg - 32'd1;
                if (skip_reg == 32'd1) begin
                    do_finish = 1'b1;
                    fin_body  = rpcw_pkg::body_of(type_reg, gather_reg);
                end
            end
            default: begin
                // idle or done: drop the byte
            end
        endcase

        if (do_finish) begin
            res_valid               = 1'b1;
            res_item.event_kind     = rpcw_pkg::EV_CMD_DONE;
            res_item.command_type   = {28'd0, fin_type};
            res_item.body_length    = fin_body;
            res_item.command_number = counter_cur;
            res_item.last_command   = (left_reg == 16'd1);
            counter_next            = counter_cur + 16'd1;
            left_next               = left_reg - 16'd1;
            phase_next = (left_reg == 16'd1) ? rpcw_pkg::PH_DONE : rpcw_pkg::PH_TYPE;
            cnt_next   = 2'd0;
        end
    end

endmodule

// ===== hdl/rpcw_out_stage.sv =====
// Result register that holds one event item until the consumer takes it.
module rpcw_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                res_valid,
    input  rpcw_pkg::out_item_t res_item,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output rpcw_pkg::out_item_t m_item
);

    logic                valid_reg;
    rpcw_pkg::out_item_t item_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            item_reg <= res_item;
        end
    end

endmodule

// ===== hdl/rts_pdu_command_walker_core.sv =====
// RTS PDU command walker: input register, byte walker and result register.
// Throughput: one byte per cycle unless a result item stalls, set by the single
// walker step per byte. A result item stalled in the result register stalls the
// walker; the input register then holds at most one byte. Reset (aresetn low,
// synchronous) empties both registers and idles the walker; bytes are dropped
// until a PDU start arrives.
module rts_pdu_command_walker_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rpcw_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rpcw_pkg::out_item_t m_item
);

    logic                in_valid;
    rpcw_pkg::in_item_t  in_item;
    logic                res_valid;
    rpcw_pkg::out_item_t res_item;
    logic                out_free;
    logic                advance;

    // step the walker when a byte is held and the result register can take its event
    assign advance = in_valid && out_free;

    rpcw_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    rpcw_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    rpcw_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res_item  (res_item),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

`ifndef SYNTHESIS
    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |-> s_ready)
        else $error("input register empty but not ready");

    a_no_step_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !advance)
        else $error("walker stepped while result item stalled");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_step_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |=> m_valid)
        else $error("event item lost on its way to the result register");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the RTS PDU command walker core.
module tb;

    localparam int PING_BIT = 0;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    rpcw_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    rpcw_pkg::out_item_t m_item;

    rts_pdu_command_walker_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    rpcw_pkg::in_item_t  pdu_bytes[$];
    rpcw_pkg::out_item_t due_events[$];
    int        error_count = 0;
    int        bytes_queued = 0;
    int        sent_count = 0;
    int        taken_count = 0;

    // Walker state mirrored by the predictor
    rpcw_pkg::phase_t wk_phase;
    logic [4:0]  wk_pos;
    logic [31:0] wk_word;
    logic [1:0]  wk_nbytes;
    logic [15:0] wk_flags;
    logic [15:0] wk_left;
    logic [15:0] wk_index;
    logic [31:0] wk_type;
    logic [32:0] wk_skip;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic int cmd_len(input logic [31:0] t);
        case (t)
            32'd1:                                      return 24;
            32'd3, 32'd12:                              return 16;
            32'd0, 32'd2, 32'd4, 32'd5, 32'd6, 32'd13, 32'd14: return 4;
            default:                                    return 0;
        endcase
    endfunction

    function automatic logic [32:0] body_now();
        logic [32:0] len;
        if (wk_type == rpcw_pkg::TYPE_PADDING) begin
            len = {1'b0, wk_word} + 33'd4;
        end else if (wk_type == rpcw_pkg::TYPE_CLIENT_ADDR) begin
            len = (wk_word == 32'd0) ? 33'd20 : 33'd32;
        end else begin
            len = 33'(cmd_len(wk_type));
        end
        return len;
    endfunction

    task automatic walker_clear();
        wk_phase  = rpcw_pkg::PH_IDLE;
        wk_pos    = '0;
        wk_word   = '0;
        wk_nbytes = '0;
        wk_flags  = '0;
        wk_left   = '0;
        wk_index  = '0;
        wk_type   = '0;
        wk_skip   = '0;
    endtask

    task automatic post(input rpcw_pkg::event_kind_t kind, input logic [31:0] ctype,
                        input logic [32:0] len, input logic [15:0] num, input logic last);
        rpcw_pkg::out_item_t ev;
        ev.event_kind     = kind;
        ev.command_type   = ctype;
        ev.body_length    = len;
        ev.command_number = num;
        ev.last_command   = last;
        due_events.push_back(ev);
    endtask

    // Collect a little-endian word; full is set on its fourth byte.
    task automatic gather_byte(input logic [7:0] b, output bit full);
        if (wk_nbytes == 2'd0) wk_word = '0;
        wk_word   = wk_word | ({24'd0, b} << (8 * wk_nbytes));
        full      = (wk_nbytes == 2'd3);
        wk_nbytes = full ? 2'd0 : wk_nbytes + 2'd1;
    endtask

    task automatic close_command(input logic [32:0] len);
        post(rpcw_pkg::EV_CMD_DONE, wk_type, len, wk_index, wk_left == 16'd1);
        wk_index  = wk_index + 16'd1;
        wk_left   = wk_left - 16'd1;
        wk_phase  = (wk_left == 16'd0) ? rpcw_pkg::PH_DONE : rpcw_pkg::PH_TYPE;
        wk_nbytes = '0;
    endtask

    task automatic walk_byte(input rpcw_pkg::in_item_t it);
        logic [7:0] b;
        bit         full;
        b = it.data_byte;
        if (it.pdu_start) begin
            walker_clear();
            wk_phase = rpcw_pkg::PH_HEADER;
        end
        case (wk_phase)
            rpcw_pkg::PH_HEADER: begin
                if (wk_pos == rpcw_pkg::POS_PTYPE && b != rpcw_pkg::RTS_PTYPE) begin
                    wk_phase = rpcw_pkg::PH_DONE;
                    post(rpcw_pkg::EV_BAD_PTYPE, {24'd0, b}, '0, '0, 1'b0);
                end else if (wk_pos == rpcw_pkg::POS_COUNT_HI) begin
                    wk_left[15:8] = b;
                    if (wk_flags[PING_BIT]) begin
                        wk_phase = rpcw_pkg::PH_DONE;
                        post(rpcw_pkg::EV_PING, '0, '0, '0, 1'b0);
                    end else if (wk_left == 16'd0) begin
                        wk_phase = rpcw_pkg::PH_DONE;
                        post(rpcw_pkg::EV_EMPTY_PDU, '0, '0, '0, 1'b0);
                    end else begin
                        wk_phase  = rpcw_pkg::PH_TYPE;
                        wk_nbytes = '0;
                    end
                end else begin
                    if (wk_pos == rpcw_pkg::POS_FLAGS_LO) wk_flags = {8'd0, b};
                    if (wk_pos == rpcw_pkg::POS_FLAGS_LO + 5'd1) wk_flags[15:8] = b;
                    if (wk_pos == rpcw_pkg::POS_COUNT_LO) wk_left = {8'd0, b};
                    wk_pos = wk_pos + 5'd1;
                end
            end
            rpcw_pkg::PH_TYPE: begin
                gather_byte(b, full);
                if (full) begin
                    wk_type = wk_word;
                    if (wk_type >= rpcw_pkg::NUM_TYPES) begin
                        wk_phase = rpcw_pkg::PH_DONE;
                        post(rpcw_pkg::EV_UNKNOWN_CMD, wk_type, '0, wk_index,
                             wk_left == 16'd1);
                    end else if (wk_type == rpcw_pkg::TYPE_PADDING ||
                                 wk_type == rpcw_pkg::TYPE_CLIENT_ADDR) begin
                        wk_phase = rpcw_pkg::PH_PARAM;
                    end else if (cmd_len(wk_type) == 0) begin
                        close_command('0);
                    end else begin
                        wk_skip  = 33'(cmd_len(wk_type));
                        wk_phase = rpcw_pkg::PH_SKIP;
                    end
                end
            end
            rpcw_pkg::PH_PARAM: begin
                gather_byte(b, full);
                if (full) begin
                    // The parameter word itself counts toward the body
                    wk_skip = body_now() - 33'd4;
                    if (wk_skip == 33'd0) close_command(body_now());
                    else wk_phase = rpcw_pkg::PH_SKIP;
                end
            end
            rpcw_pkg::PH_SKIP: begin
                if (wk_skip != 33'd0) wk_skip = wk_skip - 33'd1;
                if (wk_skip == 33'd0) close_command(body_now());
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- driver

    int gap_left = 0;
    int burst_left = 8;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item  <= '0;
        end else if (s_valid && taken_count != sent_count) begin
            // hold the item until it is taken
        end else if (gap_left != 0) begin
            s_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pdu_bytes.size() != 0) begin
            s_item  <= pdu_bytes.pop_front();
            s_valid <= 1'b1;
            sent_count++;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 48);
                gap_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- receiver

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_CHOPPY: m_ready <= ($urandom_range(0, 1) == 1);
                default:   m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        rpcw_pkg::out_item_t want;
        if (!aresetn) begin
            walker_clear();
        end else begin
            if (s_valid && s_ready) begin
                walk_byte(s_item);
                taken_count++;
            end
            if (m_valid && m_ready) begin
                if (due_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected item kind %0d type %h",
                                              m_item.event_kind, m_item.command_type));
                end else begin
                    want = due_events.pop_front();
                    if (m_item.event_kind !== want.event_kind)
                        report_mismatch($sformatf("event_kind %0d, want %0d",
                                                  m_item.event_kind, want.event_kind));
                    if (m_item.command_type !== want.command_type)
                        report_mismatch($sformatf("command_type %h, want %h",
                                                  m_item.command_type, want.command_type));
                    if (m_item.body_length !== want.body_length)
                        report_mismatch($sformatf("body_length %0d, want %0d",
                                                  m_item.body_length, want.body_length));
                    if (m_item.command_number !== want.command_number)
                        report_mismatch($sformatf("command_number %0d, want %0d",
                                                  m_item.command_number, want.command_number));
                    if (m_item.last_command !== want.last_command)
                        report_mismatch($sformatf("last_command %b, want %b",
                                                  m_item.last_command, want.last_command));
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic put(input logic [7:0] b, input logic start);
        rpcw_pkg::in_item_t it;
        it.data_byte = b;
        it.pdu_start = start;
        pdu_bytes.push_back(it);
        bytes_queued++;
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) put(w[8*i +: 8], 1'b0);
    endtask

    task automatic put_filler(input int n);
        for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic put_header(input logic [7:0] ptype, input logic [15:0] flags,
                              input logic [15:0] count);
        put(8'($urandom_range(0, 255)), 1'b1);
        put(8'($urandom_range(0, 255)), 1'b0);
        put(ptype, 1'b0);
        put_filler(13);
        put(flags[7:0], 1'b0);
        put(flags[15:8], 1'b0);
        put(count[7:0], 1'b0);
        put(count[15:8], 1'b0);
    endtask

    task automatic put_bad_header();
        logic [7:0] bad;
        bad = 8'($urandom_range(0, 255));
        if (bad == rpcw_pkg::RTS_PTYPE) bad = ~bad;
        put(8'($urandom_range(0, 255)), 1'b1);
        put(8'($urandom_range(0, 255)), 1'b0);
        put(bad, 1'b0);
    endtask

    // Type word plus a body matching it; param only matters for variable types
    task automatic put_command(input logic [31:0] ctype, input logic [31:0] param);
        put_word(ctype);
        if (ctype == rpcw_pkg::TYPE_PADDING) begin
            put_word(param);
            put_filler(int'(param));
        end else if (ctype == rpcw_pkg::TYPE_CLIENT_ADDR) begin
            put_word(param);
            put_filler((param == 32'd0) ? 16 : 28);
        end else if (ctype < rpcw_pkg::NUM_TYPES) begin
            put_filler(cmd_len(ctype));
        end
    endtask

    task automatic put_random_command();
        logic [31:0] t;
        logic [31:0] p;
        if ($urandom_range(0, 3) == 0)
            t = $urandom_range(0, 1) ? {28'd0, rpcw_pkg::TYPE_PADDING}
                                     : {28'd0, rpcw_pkg::TYPE_CLIENT_ADDR};
        else t = $urandom_range(0, 14);
        if (t == rpcw_pkg::TYPE_PADDING)
            p = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        else
            p = $urandom_range(0, 1) ? 32'd0 : $urandom;
        put_command(t, p);
    endtask

    function automatic logic [31:0] unknown_type();
        logic [31:0] t;
        t = $urandom_range(0, 1) ? $urandom_range(15, 255) : $urandom;
        if (t < rpcw_pkg::NUM_TYPES) t = rpcw_pkg::NUM_TYPES;
        return t;
    endfunction

    task automatic put_random_pdu();
        int          pick;
        int          n;
        logic [15:0] flags;
        pick  = $urandom_range(0, 99);
        flags = 16'($urandom_range(0, 16'hFFFF));
        n     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
        flags[PING_BIT] = 1'b0;
        if (pick < 62) begin
            put_header(rpcw_pkg::RTS_PTYPE, flags, 16'(n));
            for (int i = 0; i < n; i++) put_random_command();
            put_filler($urandom_range(0, 3));
        end else if (pick < 70) begin
            // declared count exceeds what arrives: the next start abandons it
            put_header(rpcw_pkg::RTS_PTYPE, flags, 16'(n + $urandom_range(1, 3)));
            for (int i = 0; i < n; i++) put_random_command();
            put_filler($urandom_range(0, 6));
        end else if (pick < 76) begin
            put_header(rpcw_pkg::RTS_PTYPE, flags, 16'(n + $urandom_range(0, 2)));
            for (int i = 1; i < n; i++) put_random_command();
            put_command(unknown_type(), 32'd0);
            put_filler($urandom_range(0, 6));
        end else if (pick < 82) begin
            flags[PING_BIT] = 1'b1;
            put_header(rpcw_pkg::RTS_PTYPE, flags, 16'($urandom_range(0, 16'hFFFF)));
            put_filler($urandom_range(0, 6));
        end else if (pick < 87) begin
            put_header(rpcw_pkg::RTS_PTYPE, flags, 16'd0);
            put_filler($urandom_range(0, 4));
        end else if (pick < 93) begin
            put_bad_header();
            put_filler($urandom_range(0, 5));
        end else begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                put(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic wait_all_answered();
        while (pdu_bytes.size() != 0 || taken_count != sent_count || due_events.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        // bytes ahead of any start are dropped
        put(8'hA5, 1'b0);
        put(8'h5A, 1'b0);
        // bad packet type at both byte extremes
        put(8'hFF, 1'b1); put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'hFF, 1'b0);
        put(8'h00, 1'b1); put(8'hFF, 1'b0); put(8'hFF, 1'b0);
        put_header(rpcw_pkg::RTS_PTYPE, 16'hFFFE, 16'd0);
        put(8'h00, 1'b0);
        put_header(rpcw_pkg::RTS_PTYPE, 16'hFFFF, 16'hFFFF);
        put_filler(2);
        // header cut short by the next start
        put(8'h00, 1'b1); put(8'h00, 1'b0); put(rpcw_pkg::RTS_PTYPE, 1'b0);
        put_filler(4);
        // every known type, then the variable ones at their edges
        put_header(rpcw_pkg::RTS_PTYPE, 16'h0000, 16'd18);
        for (int t = 0; t < rpcw_pkg::NUM_TYPES; t++) put_command(32'(t), 32'd0);
        put_command({28'd0, rpcw_pkg::TYPE_PADDING}, 32'd3);
        put_command({28'd0, rpcw_pkg::TYPE_CLIENT_ADDR}, 32'hFFFF_FFFF);
        put_command({28'd0, rpcw_pkg::TYPE_CLIENT_ADDR}, 32'd1);
        put_filler(3);
        put_header(rpcw_pkg::RTS_PTYPE, 16'h0000, 16'd3);
        put_command(32'd7, 32'd0);
        put_command(32'hFFFF_FFFF, 32'd0);
        put_filler(4);
        put_header(rpcw_pkg::RTS_PTYPE, 16'h0000, 16'd1);
        put_command(rpcw_pkg::NUM_TYPES, 32'd0);
        // huge padding count, abandoned by a new start
        put_header(rpcw_pkg::RTS_PTYPE, 16'h0000, 16'hFFFF);
        put_word({28'd0, rpcw_pkg::TYPE_PADDING});
        put_word(32'hFFFF_FFFF);
        put_filler(5);
        put_header(rpcw_pkg::RTS_PTYPE, 16'h0000, 16'd1);
        put_command(32'd7, 32'd0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // let everything drain before the random part
        wait_all_answered();

        while (bytes_queued < 700) begin
            put_random_pdu();
            if ($urandom_range(0, 3) == 0) begin
                wait_all_answered();
            end else begin
                while (pdu_bytes.size() > 8) @(posedge aclk);
            end
        end

        wait_all_answered();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
